// ----- rtl/teq_pkg.sv -----
// shared types, codes and constants for the timed event queue
`default_nettype none
package teq_pkg;

  localparam int unsigned CapacityDef   = 64;
  localparam int unsigned MaxOutDef     = 16;
  localparam int unsigned TimeBitsDef   = 32;
  localparam int unsigned HandleBitsDef = 32;

  // function codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUE      = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] stamp;
    logic [31:0] handle;
  } teq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_handle;
    logic [31:0] out_time;
    logic        last;
    logic [6:0]  dropped;
  } teq_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       clear;
    logic       ins_start;
    logic       pop_start;
    logic       rd_prev;
    logic       rd_cur;
    logic       shift;
    logic       place;
    logic       idx_inc;
    logic       pop_end;
    logic       out_load;
    logic [2:0] out_status;
    logic       commit;
  } teq_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       idx_zero;
    logic       idx_at_count;
    logic       rd_gt;
    logic       emit_last;
    logic       out_valid;
  } teq_stat_t;

endpackage
`default_nettype wire

// ----- rtl/teq_ram.sv -----
// generic single-write, single-read ram with registered read
`default_nettype none
module teq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/teq_datapath.sv -----
// datapath: circular event table, scan counters and output register
`default_nettype none
module teq_datapath #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned MAX_OUT     = 16,
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire teq_pkg::teq_in_t  in_data,
  input  wire teq_pkg::teq_cmd_t cmd,
  output teq_pkg::teq_stat_t     stat,
  output teq_pkg::teq_out_t      out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import teq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = TIME_BITS + HANDLE_BITS;

  logic [TIME_BITS-1:0]   t_reg;
  logic [HANDLE_BITS-1:0] h_reg;
  logic [1:0]             func;
  logic [AW-1:0]          head;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic [CW-1:0]          ndue;
  logic [63:0]            in_time_w;
  logic [63:0]            in_handle_w;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [EW-1:0]          rdata;
  logic [TIME_BITS-1:0]   rd_time;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [63:0]            rd_time_w;
  logic [63:0]            rd_handle_w;
  logic [CW-1:0]          given;
  logic [CW+7:0]          rest_w;
  logic [6:0]             drop;
  logic [CW-1:0]          idx_prev;

  // logical slot to physical address, modulo capacity
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, base} + {1'b0, i};
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign in_time_w   = {32'd0, in_data.stamp};
  assign in_handle_w = {32'd0, in_data.handle};
  assign rd_time     = rdata[EW-1:HANDLE_BITS];
  assign rd_handle   = rdata[HANDLE_BITS-1:0];
  assign rd_time_w   = 64'(rd_time);
  assign rd_handle_w = 64'(rd_handle);
  assign idx_prev    = idx - CW'(1);

  // emit limit and dropped count
  assign given  = ({8'd0, ndue} > (CW+8)'(MAX_OUT)) ? CW'(MAX_OUT) : ndue;
  assign rest_w = {8'd0, ndue} - {8'd0, given};
  assign drop   = (rest_w > (CW+8)'(127)) ? 7'd127 : rest_w[6:0];

  // ram ports
  assign re    = cmd.rd_prev | cmd.rd_cur;
  assign raddr = phys(head, cmd.rd_prev ? idx_prev : idx);
  assign we    = cmd.shift | cmd.place;
  assign waddr = phys(head, idx);
  assign wdata = cmd.shift ? rdata : {t_reg, h_reg};

  teq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // status to controller
  assign stat.func         = func;
  assign stat.full         = (count == CW'(CAPACITY));
  assign stat.idx_zero     = (idx == '0);
  assign stat.idx_at_count = (idx == count);
  assign stat.rd_gt        = (rd_time > t_reg);
  assign stat.emit_last    = ((idx + CW'(1)) == given);
  assign stat.out_valid    = out_valid;

  // input capture, table control and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
      ndue  <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.ins_start) begin
        idx <= count;
      end
      if (cmd.pop_start) begin
        idx <= '0;
      end
      if (cmd.shift) begin
        idx <= idx_prev;
      end
      if (cmd.place) begin
        count <= count + CW'(1);
      end
      if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      if (cmd.pop_end) begin
        ndue <= idx;
        idx  <= '0;
      end
      if (cmd.commit) begin
        head  <= phys(head, ndue);
        count <= count - ndue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func  <= in_data.func;
      t_reg <= in_time_w[TIME_BITS-1:0];
      h_reg <= in_handle_w[HANDLE_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status <= cmd.out_status;
      if (cmd.out_status == ST_DUE) begin
        out_data.out_handle <= rd_handle_w[31:0];
        out_data.out_time   <= rd_time_w[31:0];
        out_data.last       <= stat.emit_last;
        out_data.dropped    <= stat.emit_last ? drop : 7'd0;
      end else begin
        out_data.out_handle <= '0;
        out_data.out_time   <= '0;
        out_data.last       <= 1'b1;
        out_data.dropped    <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/teq_ctrl.sv -----
// controller state machine sequencing insert, pop and clear
`default_nettype none
module teq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire teq_pkg::teq_stat_t stat,
  input  wire logic               out_ready,
  output teq_pkg::teq_cmd_t       cmd
);
  import teq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_CHK,
    S_INS_CMP,
    S_POP_CHK,
    S_POP_CMP,
    S_POP_END,
    S_EMIT_RD,
    S_EMIT_LD,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   more;
  logic   more_next;

  assign in_ready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    more_next  = more;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.func)
          FN_INSERT: begin
            if (stat.full) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_FULL;
              more_next      = 1'b0;
              state_next     = S_OUT;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_INS_CHK;
            end
          end
          FN_POP: begin
            cmd.pop_start = 1'b1;
            state_next    = S_POP_CHK;
          end
          FN_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_CLEARED;
            more_next      = 1'b0;
            state_next     = S_OUT;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.idx_zero) begin
          cmd.place      = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_INSERTED;
          more_next      = 1'b0;
          state_next     = S_OUT;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.rd_gt) begin
          cmd.shift  = 1'b1;
          state_next = S_INS_CHK;
        end else begin
          cmd.place      = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_INSERTED;
          more_next      = 1'b0;
          state_next     = S_OUT;
        end
      end
      S_POP_CHK: begin
        if (stat.idx_at_count) begin
          state_next = S_POP_END;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        if (stat.rd_gt) begin
          state_next = S_POP_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_POP_CHK;
        end
      end
      S_POP_END: begin
        if (stat.idx_zero) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_NONE;
          more_next      = 1'b0;
          state_next     = S_OUT;
        end else begin
          cmd.pop_end = 1'b1;
          state_next  = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_cur = 1'b1;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.out_load   = 1'b1;
        cmd.out_status = ST_DUE;
        cmd.idx_inc    = 1'b1;
        cmd.commit     = stat.emit_last;
        more_next      = !stat.emit_last;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (stat.out_valid && out_ready) begin
          state_next = more ? S_EMIT_RD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      more  <= 1'b0;
    end else begin
      state <= state_next;
      more  <= more_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/timed_event_queue.sv -----
// Timed event queue: a time-sorted table of up to CAPACITY events held in one
// memory used as a ring. One transaction is taken at a time. An insert walks
// back from the tail one entry at a time, moving later entries up. A pop scans
// the due entries, then gives up to MAX_OUT due events, one per output
// transaction; all due events leave the table and dropped reports the rest on
// the last one. Inserts and pops are paced by the single memory read port.
// No clearing pass is needed after reset.
`default_nettype none
module timed_event_queue #(
  parameter int unsigned CAPACITY    = teq_pkg::CapacityDef,
  parameter int unsigned MAX_OUT     = teq_pkg::MaxOutDef,
  parameter int unsigned TIME_BITS   = teq_pkg::TimeBitsDef,
  parameter int unsigned HANDLE_BITS = teq_pkg::HandleBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire teq_pkg::teq_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output teq_pkg::teq_out_t      out_data
);
  import teq_pkg::*;

  teq_cmd_t  cmd;
  teq_stat_t stat;

  // sequencing
  teq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  // table and output
  teq_datapath #(
    .CAPACITY   (CAPACITY),
    .MAX_OUT    (MAX_OUT),
    .TIME_BITS  (TIME_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule
`default_nettype wire
